@@ rtl/core/bbfc_pkg.sv @@
// Shared constants, codes and helpers for the boot bank fallback controller
`default_nettype none
package bbfc_pkg;

    localparam int CNT_W = 16;
    localparam int OUT_CNT_W = 16;
    localparam int CMP_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTH_DIS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BL_JUMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIM  = 3'd5;

    localparam logic [1:0] KIND_BANK_CHECK = 2'd0;
    localparam logic [1:0] KIND_BOOT_FAIL  = 2'd1;
    localparam logic [1:0] KIND_APP_FAIL   = 2'd2;
    localparam logic [1:0] KIND_HARD_FAULT = 2'd3;

    localparam logic [1:0] CHOICE_INVALID = 2'd0;
    localparam logic [1:0] CHOICE_BANK_B  = 2'd1;
    localparam logic [1:0] CHOICE_BANK_A  = 2'd2;

    localparam logic [1:0] ACT_CONT  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_SLEEP = 2'd2;
    localparam logic [1:0] ACT_FBL   = 2'd3;

    localparam logic [2:0] ST_A_OK    = 3'd0;
    localparam logic [2:0] ST_A_FAIL  = 3'd1;
    localparam logic [2:0] ST_B_OK    = 3'd2;
    localparam logic [2:0] ST_B_FAIL  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [1:0] FC_NONE = 2'd0;
    localparam logic [1:0] FC_BOOT = 2'd1;
    localparam logic [1:0] FC_APP  = 2'd2;

    function automatic logic [OUT_CNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] t;
        t = CMP_W'(c);
        return t[OUT_CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/boot_bank_fallback_controller.sv @@
// Boot bank fallback controller: bank selection and failure escalation
// An accepted transaction's result is on the output register in the cycle after it is accepted.
// Throughput: one transaction per cycle; input ready drops only while a result is stalled.
// All event logic is one pass of compares and counter updates between state and result.
// Synchronous active-low reset: counters, flags and switch cleared, status unknown,
// configuration back to its defaults, output register empty.
`default_nettype none
module boot_bank_fallback_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [bbfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bbfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [31:0]                   i_magic_word,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_bank_choice,
    output logic [1:0]                         o_action,
    output logic [2:0]                         o_app_state,
    output logic [1:0]                         o_fault_flag_a,
    output logic [1:0]                         o_fault_flag_b,
    output logic                               o_switch_pending,
    output logic [15:0]                        o_retry_count,
    output logic [15:0]                        o_fault_count
);

    logic [31:0] r_magic_a;
    logic [31:0] r_magic_b;
    logic        r_auth_dis;
    logic        r_bl_jump;
    logic [15:0] r_retry_lim;
    logic [15:0] r_fault_lim;

    logic [bbfc_pkg::CNT_W-1:0] r_retry_cnt, n_retry_cnt;
    logic [bbfc_pkg::CNT_W-1:0] r_fault_cnt, n_fault_cnt;
    logic       r_switch, n_switch;
    logic [2:0] r_status, n_status;
    logic [1:0] r_flag_a, n_flag_a;
    logic [1:0] r_flag_b, n_flag_b;
    logic [1:0] n_choice;
    logic [1:0] n_action;

    logic r_out_valid;
    logic in_acc;

    logic [bbfc_pkg::CMP_W-1:0] retry_ext, retry_lim_ext, fault_ext, fault_lim_ext;
    logic       log_to_a;
    logic [1:0] fail_code;

    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    assign retry_ext     = bbfc_pkg::CMP_W'(r_retry_cnt);
    assign retry_lim_ext = bbfc_pkg::CMP_W'(r_retry_lim);
    assign fault_ext     = bbfc_pkg::CMP_W'(r_fault_cnt);
    assign fault_lim_ext = bbfc_pkg::CMP_W'(r_fault_lim);

    always_comb begin
        n_retry_cnt = r_retry_cnt;
        n_fault_cnt = r_fault_cnt;
        n_switch    = r_switch;
        n_status    = r_status;
        n_flag_a    = r_flag_a;
        n_flag_b    = r_flag_b;
        n_choice    = bbfc_pkg::CHOICE_INVALID;
        n_action    = bbfc_pkg::ACT_CONT;
        log_to_a    = 1'b0;
        fail_code   = bbfc_pkg::FC_BOOT;
        case (i_kind)
            bbfc_pkg::KIND_BANK_CHECK: begin
                if (r_auth_dis) begin
                    n_flag_a = bbfc_pkg::FC_NONE;
                    n_flag_b = bbfc_pkg::FC_NONE;
                    n_switch = 1'b0;
                end
                n_status = bbfc_pkg::ST_A_OK;
                if (i_magic_word == r_magic_b) begin
                    n_choice = bbfc_pkg::CHOICE_BANK_B;
                    n_status = bbfc_pkg::ST_B_OK;
                end else if (i_magic_word == r_magic_a) begin
                    n_choice = bbfc_pkg::CHOICE_BANK_A;
                end
                if (n_switch) begin
                    if (n_choice == bbfc_pkg::CHOICE_BANK_B) begin
                        n_choice = bbfc_pkg::CHOICE_BANK_A;
                        n_status = bbfc_pkg::ST_A_OK;
                    end else begin
                        n_choice = bbfc_pkg::CHOICE_BANK_B;
                        n_status = bbfc_pkg::ST_B_OK;
                    end
                end
            end
            bbfc_pkg::KIND_BOOT_FAIL, bbfc_pkg::KIND_APP_FAIL: begin
                if (i_kind == bbfc_pkg::KIND_APP_FAIL) begin
                    n_status  = (r_status == bbfc_pkg::ST_A_OK) ? bbfc_pkg::ST_A_FAIL
                                                                : bbfc_pkg::ST_B_FAIL;
                    fail_code = bbfc_pkg::FC_APP;
                    log_to_a  = (n_status == bbfc_pkg::ST_A_FAIL);
                end else begin
                    log_to_a  = (r_status == bbfc_pkg::ST_A_OK);
                end
                n_action = bbfc_pkg::ACT_RESET;
                if (retry_ext < retry_lim_ext) begin
                    n_retry_cnt = r_retry_cnt + bbfc_pkg::CNT_W'(1);
                end else if (retry_ext == retry_lim_ext) begin
                    n_retry_cnt = r_retry_cnt + bbfc_pkg::CNT_W'(1);
                    if (r_bl_jump) begin
                        n_action = bbfc_pkg::ACT_FBL;
                    end else begin
                        if (log_to_a) begin
                            n_flag_a = fail_code;
                        end else begin
                            n_flag_b = fail_code;
                        end
                        if (r_switch) begin
                            n_switch = 1'b0;
                            n_action = bbfc_pkg::ACT_SLEEP;
                        end else begin
                            n_switch    = 1'b1;
                            n_retry_cnt = '0;
                        end
                    end
                end else begin
                    n_retry_cnt = bbfc_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_action = bbfc_pkg::ACT_RESET;
                if (fault_ext < fault_lim_ext) begin
                    n_fault_cnt = r_fault_cnt + bbfc_pkg::CNT_W'(1);
                end else if (fault_ext == fault_lim_ext) begin
                    n_fault_cnt = r_fault_cnt + bbfc_pkg::CNT_W'(1);
                    n_action    = bbfc_pkg::ACT_SLEEP;
                end else begin
                    n_fault_cnt = bbfc_pkg::CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_a   <= 32'd1;
            r_magic_b   <= 32'd2;
            r_auth_dis  <= 1'b0;
            r_bl_jump   <= 1'b0;
            r_retry_lim <= 16'd2;
            r_fault_lim <= 16'd2;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                bbfc_pkg::CFG_MAGIC_A:   r_magic_a   <= i_cfg_wdata;
                bbfc_pkg::CFG_MAGIC_B:   r_magic_b   <= i_cfg_wdata;
                bbfc_pkg::CFG_AUTH_DIS:  r_auth_dis  <= i_cfg_wdata[0];
                bbfc_pkg::CFG_BL_JUMP:   r_bl_jump   <= i_cfg_wdata[0];
                bbfc_pkg::CFG_RETRY_LIM: r_retry_lim <= i_cfg_wdata[15:0];
                bbfc_pkg::CFG_FAULT_LIM: r_fault_lim <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_cnt <= '0;
            r_fault_cnt <= '0;
            r_switch    <= 1'b0;
            r_status    <= bbfc_pkg::ST_UNKNOWN;
            r_flag_a    <= bbfc_pkg::FC_NONE;
            r_flag_b    <= bbfc_pkg::FC_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_retry_cnt <= n_retry_cnt;
                r_fault_cnt <= n_fault_cnt;
                r_switch    <= n_switch;
                r_status    <= n_status;
                r_flag_a    <= n_flag_a;
                r_flag_b    <= n_flag_b;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            o_bank_choice    <= n_choice;
            o_action         <= n_action;
            o_app_state      <= n_status;
            o_fault_flag_a   <= n_flag_a;
            o_fault_flag_b   <= n_flag_b;
            o_switch_pending <= n_switch;
            o_retry_count    <= bbfc_pkg::cnt_to_out(n_retry_cnt);
            o_fault_count    <= bbfc_pkg::cnt_to_out(n_fault_cnt);
        end
    end

`ifndef SYNTHESIS
    a_bank_check_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == bbfc_pkg::KIND_BANK_CHECK) |=> o_action == bbfc_pkg::ACT_CONT)
        else $error("bank check gave an action other than continue");

    a_choice_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind != bbfc_pkg::KIND_BANK_CHECK)
        |=> o_bank_choice == bbfc_pkg::CHOICE_INVALID)
        else $error("bank choice set on a failure transaction");

    a_auth_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == bbfc_pkg::KIND_BANK_CHECK) && r_auth_dis
        |=> !o_switch_pending && (o_fault_flag_a == bbfc_pkg::FC_NONE)
            && (o_fault_flag_b == bbfc_pkg::FC_NONE))
        else $error("auth disabled check left flags set");

    a_switch_forces_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == bbfc_pkg::KIND_BANK_CHECK) && r_switch && !r_auth_dis
        |=> o_bank_choice != bbfc_pkg::CHOICE_INVALID)
        else $error("pending switch gave an invalid bank");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_app_state <= bbfc_pkg::ST_UNKNOWN)
        else $error("application state code out of range");
`endif

endmodule
`default_nettype wire

@@ bench/boot_bank_fallback_controller_tb.sv @@
// Self-checking testbench for the boot bank fallback controller: predicted responses vs DUT
module boot_bank_fallback_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_EVENTS   = 210;
    localparam int STALL_PHASE    = 3;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 3;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word;
    } t_boot_event;

    typedef struct packed {
        logic [1:0]  choice;
        logic [1:0]  action;
        logic [2:0]  app_state;
        logic [1:0]  flag_a;
        logic [1:0]  flag_b;
        logic        sw_pending;
        logic [15:0] retry_cnt;
        logic [15:0] fault_cnt;
    } t_boot_response;

    logic                            i_clk;
    logic                            i_rst_n      = 1'b0;
    logic                            i_cfg_wr_en  = 1'b0;
    logic [bbfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx    = bbfc_pkg::CFG_MAGIC_A;
    logic [bbfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata  = '0;
    logic                            i_valid      = 1'b0;
    logic                            o_ready;
    logic [1:0]                      i_kind       = bbfc_pkg::KIND_BANK_CHECK;
    logic [31:0]                     i_magic_word = '0;
    logic                            o_valid;
    logic                            i_ready      = 1'b0;
    logic [1:0]                      o_bank_choice;
    logic [1:0]                      o_action;
    logic [2:0]                      o_app_state;
    logic [1:0]                      o_fault_flag_a;
    logic [1:0]                      o_fault_flag_b;
    logic                            o_switch_pending;
    logic [15:0]                     o_retry_count;
    logic [15:0]                     o_fault_count;

    boot_bank_fallback_controller uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_magic_word     (i_magic_word),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_bank_choice    (o_bank_choice),
        .o_action         (o_action),
        .o_app_state      (o_app_state),
        .o_fault_flag_a   (o_fault_flag_a),
        .o_fault_flag_b   (o_fault_flag_b),
        .o_switch_pending (o_switch_pending),
        .o_retry_count    (o_retry_count),
        .o_fault_count    (o_fault_count)
    );

    // settings as last written
    logic [31:0] cfg_magic_a   = 32'd1;
    logic [31:0] cfg_magic_b   = 32'd2;
    logic        cfg_auth_off  = 1'b0;
    logic        cfg_bl_jump   = 1'b0;
    logic [15:0] cfg_retry_lim = 16'd2;
    logic [15:0] cfg_fault_lim = 16'd2;

    // predicted controller state
    logic [15:0] image_retries  = '0;
    logic [15:0] hard_faults    = '0;
    logic        switch_ordered = 1'b0;
    logic [2:0]  bank_status    = bbfc_pkg::ST_UNKNOWN;
    logic [1:0]  fault_code_a   = bbfc_pkg::FC_NONE;
    logic [1:0]  fault_code_b   = bbfc_pkg::FC_NONE;

    t_boot_event    pending_events[$];
    t_boot_response awaited_responses[$];

    int mismatches    = 0;
    int results_seen  = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int rx_cycle      = 0;
    int rx_hold       = 0;
    int tx_gap        = 0;
    int tx_burst      = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [1:0] escalate_image_failure(logic [1:0] code, logic [2:0] a_status);
        logic first;
        if (image_retries < cfg_retry_lim) begin
            image_retries = image_retries + 16'd1;
            return bbfc_pkg::ACT_RESET;
        end
        if (image_retries != cfg_retry_lim) begin
            image_retries = 16'd1;
            return bbfc_pkg::ACT_RESET;
        end
        image_retries = image_retries + 16'd1;
        if (cfg_bl_jump) begin
            return bbfc_pkg::ACT_FBL;
        end
        first = !switch_ordered;
        if (bank_status == a_status) begin
            fault_code_a = code;
        end else begin
            fault_code_b = code;
        end
        if (!first) begin
            switch_ordered = 1'b0;
            return bbfc_pkg::ACT_SLEEP;
        end
        switch_ordered = 1'b1;
        image_retries  = '0;
        return bbfc_pkg::ACT_RESET;
    endfunction

    function automatic void predict_boot_response(t_boot_event ev);
        t_boot_response r;
        r        = '0;
        r.choice = bbfc_pkg::CHOICE_INVALID;
        r.action = bbfc_pkg::ACT_CONT;
        case (ev.kind)
            bbfc_pkg::KIND_BANK_CHECK: begin
                if (cfg_auth_off) begin
                    fault_code_a   = bbfc_pkg::FC_NONE;
                    fault_code_b   = bbfc_pkg::FC_NONE;
                    switch_ordered = 1'b0;
                end
                bank_status = bbfc_pkg::ST_A_OK;
                if (ev.word == cfg_magic_b) begin
                    r.choice    = bbfc_pkg::CHOICE_BANK_B;
                    bank_status = bbfc_pkg::ST_B_OK;
                end else if (ev.word == cfg_magic_a) begin
                    r.choice = bbfc_pkg::CHOICE_BANK_A;
                end
                // pending switch inverts the pick
                if (switch_ordered) begin
                    if (r.choice == bbfc_pkg::CHOICE_BANK_B) begin
                        r.choice    = bbfc_pkg::CHOICE_BANK_A;
                        bank_status = bbfc_pkg::ST_A_OK;
                    end else begin
                        r.choice    = bbfc_pkg::CHOICE_BANK_B;
                        bank_status = bbfc_pkg::ST_B_OK;
                    end
                end
            end
            bbfc_pkg::KIND_BOOT_FAIL: begin
                r.action = escalate_image_failure(bbfc_pkg::FC_BOOT, bbfc_pkg::ST_A_OK);
            end
            bbfc_pkg::KIND_APP_FAIL: begin
                bank_status = (bank_status == bbfc_pkg::ST_A_OK) ? bbfc_pkg::ST_A_FAIL
                                                                 : bbfc_pkg::ST_B_FAIL;
                r.action    = escalate_image_failure(bbfc_pkg::FC_APP, bbfc_pkg::ST_A_FAIL);
            end
            default: begin
                if (hard_faults < cfg_fault_lim) begin
                    hard_faults = hard_faults + 16'd1;
                    r.action    = bbfc_pkg::ACT_RESET;
                end else if (hard_faults == cfg_fault_lim) begin
                    hard_faults = hard_faults + 16'd1;
                    r.action    = bbfc_pkg::ACT_SLEEP;
                end else begin
                    hard_faults = 16'd1;
                    r.action    = bbfc_pkg::ACT_RESET;
                end
            end
        endcase
        r.app_state  = bank_status;
        r.flag_a     = fault_code_a;
        r.flag_b     = fault_code_b;
        r.sw_pending = switch_ordered;
        r.retry_cnt  = image_retries;
        r.fault_cnt  = hard_faults;
        awaited_responses.push_back(r);
    endfunction

    function automatic void queue_event(logic [1:0] kind, logic [31:0] word);
        t_boot_event ev;
        ev.kind = kind;
        ev.word = word;
        pending_events.push_back(ev);
    endfunction

    function automatic logic [31:0] pick_check_word();
        case ($urandom_range(0, 5))
            0, 1:    return cfg_magic_a;
            2, 3:    return cfg_magic_b;
            4:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // mostly boot cycles (check, then a run of image failures) and hard fault runs
    function automatic void queue_boot_traffic(int count);
        int added;
        int run;
        int cap;
        added = 0;
        while (added < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    queue_event(bbfc_pkg::KIND_BANK_CHECK, pick_check_word());
                    cap = (cfg_retry_lim > 16'd6) ? 6 : int'(cfg_retry_lim);
                    run = $urandom_range(0, cap + 3);
                    repeat (run) begin
                        queue_event($urandom_range(0, 1) ? bbfc_pkg::KIND_APP_FAIL
                                                         : bbfc_pkg::KIND_BOOT_FAIL,
                                    $urandom);
                    end
                    added += run + 1;
                end
                5, 6: begin
                    cap = (cfg_fault_lim > 16'd6) ? 6 : int'(cfg_fault_lim);
                    run = $urandom_range(1, cap + 2);
                    repeat (run) begin
                        queue_event(bbfc_pkg::KIND_HARD_FAULT, $urandom);
                    end
                    added += run;
                end
                default: begin
                    queue_event(2'($urandom_range(0, 3)), $urandom);
                    added++;
                end
            endcase
        end
    endfunction

    task automatic write_reg(logic [bbfc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bbfc_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
    endtask

    // narrow registers sometimes carry junk in the unused upper bits
    task automatic apply_settings(logic [31:0] magic_a, logic [31:0] magic_b, logic auth_off,
                                  logic bl_jump, logic [15:0] retry_lim, logic [15:0] fault_lim);
        logic [31:0] junk;
        junk = $urandom_range(0, 1) ? $urandom : 32'h0;
        write_reg(bbfc_pkg::CFG_MAGIC_A, magic_a);
        write_reg(bbfc_pkg::CFG_MAGIC_B, magic_b);
        write_reg(bbfc_pkg::CFG_AUTH_DIS, {junk[31:1], auth_off});
        write_reg(bbfc_pkg::CFG_BL_JUMP, {junk[31:1], bl_jump});
        write_reg(bbfc_pkg::CFG_RETRY_LIM, {junk[31:16], retry_lim});
        write_reg(bbfc_pkg::CFG_FAULT_LIM, {junk[31:16], fault_lim});
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cfg_magic_a   = magic_a;
        cfg_magic_b   = magic_b;
        cfg_auth_off  = auth_off;
        cfg_bl_jump   = bl_jump;
        cfg_retry_lim = retry_lim;
        cfg_fault_lim = fault_lim;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || awaited_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    initial begin : stimulus
        logic [31:0] ma;
        logic [31:0] mb;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed run on reset settings
        queue_event(bbfc_pkg::KIND_APP_FAIL, 32'h0);    // app failure while status unknown
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'd2);
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'd1);
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'h0);
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'hFFFF_FFFF);
        queue_event(bbfc_pkg::KIND_BOOT_FAIL, 32'hFFFF_FFFF);
        queue_event(bbfc_pkg::KIND_BOOT_FAIL, 32'h0);   // limit: log on A, order switch
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'd2);  // inverted pick
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'd1);
        queue_event(bbfc_pkg::KIND_APP_FAIL, 32'h5555_5555);
        queue_event(bbfc_pkg::KIND_APP_FAIL, 32'hAAAA_AAAA);
        queue_event(bbfc_pkg::KIND_APP_FAIL, 32'h0);    // limit with switch pending: sleep
        queue_event(bbfc_pkg::KIND_APP_FAIL, 32'h0);    // above limit
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'd3);
        queue_event(bbfc_pkg::KIND_APP_FAIL, 32'h0);
        repeat (4) queue_event(bbfc_pkg::KIND_HARD_FAULT, 32'hFFFF_FFFF);
        queue_event(bbfc_pkg::KIND_BANK_CHECK, 32'd1);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            ma = $urandom;
            mb = $urandom;
            case (ph)
                0: apply_settings(ma, mb, 1'b0, 1'b0, 16'd0, 16'd0);
                1: apply_settings(ma, ma, 1'b1, 1'b0, 16'd3, 16'd1);
                2: apply_settings(32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'd1, 16'd65534);
                3: apply_settings(ma, mb, 1'b0, 1'b0, 16'd65534, 16'd4);
                4: apply_settings(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 16'd2, 16'd0);
                7: apply_settings(ma, mb, 1'b0, 1'b0, 16'd1, 16'd2);
                default: apply_settings(ma, mb, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)),
                                        16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)));
            endcase
            queue_boot_traffic(PHASE_EVENTS);
            if (ph == STALL_PHASE) begin
                hold_requests++;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("boot_bank_fallback_controller regression: pass");
        end else begin
            $display("boot_bank_fallback_controller regression: fail");
        end
        $finish;
    end

    // sender: bursts of random length, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap   = 0;
            tx_burst = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_boot_response(pending_events.pop_front());
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid      <= 1'b1;
                    i_kind       <= pending_events[0].kind;
                    i_magic_word <= pending_events[0].word;
                    if (tx_burst > 0) begin
                        tx_burst--;
                    end else begin
                        tx_burst = $urandom_range(1, 40);
                        tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: pattern chosen by bits 8:6 of its cycle counter, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_cycle = 0;
            rx_hold  = 0;
        end else begin
            rx_cycle++;
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (holds_done != hold_requests) begin
                holds_done++;
                rx_hold = LONG_HOLD;
                i_ready <= 1'b0;
            end else begin
                case (rx_cycle[8:6])
                    3'd0, 3'd1: i_ready <= 1'b1;
                    3'd2:       i_ready <= 1'($urandom_range(0, 1));
                    3'd3:       i_ready <= (rx_cycle[1:0] == 2'd0);
                    3'd4:       i_ready <= ($urandom_range(0, 3) != 0);
                    3'd5:       i_ready <= rx_cycle[2];
                    default:    i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_boot_response want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (awaited_responses.size() == 0) begin
                report_mismatch("result with no transaction awaiting it");
            end else begin
                want = awaited_responses.pop_front();
                if (o_bank_choice !== want.choice)
                    report_mismatch($sformatf("bank_choice %0d, expected %0d",
                                              o_bank_choice, want.choice));
                if (o_action !== want.action)
                    report_mismatch($sformatf("action %0d, expected %0d",
                                              o_action, want.action));
                if (o_app_state !== want.app_state)
                    report_mismatch($sformatf("app_state %0d, expected %0d",
                                              o_app_state, want.app_state));
                if (o_fault_flag_a !== want.flag_a)
                    report_mismatch($sformatf("fault_flag_a %0d, expected %0d",
                                              o_fault_flag_a, want.flag_a));
                if (o_fault_flag_b !== want.flag_b)
                    report_mismatch($sformatf("fault_flag_b %0d, expected %0d",
                                              o_fault_flag_b, want.flag_b));
                if (o_switch_pending !== want.sw_pending)
                    report_mismatch($sformatf("switch_pending %0d, expected %0d",
                                              o_switch_pending, want.sw_pending));
                if (o_retry_count !== want.retry_cnt)
                    report_mismatch($sformatf("retry_count %0d, expected %0d",
                                              o_retry_count, want.retry_cnt));
                if (o_fault_count !== want.fault_cnt)
                    report_mismatch($sformatf("fault_count %0d, expected %0d",
                                              o_fault_count, want.fault_cnt));
            end
        end
    end

    // ends the run after too many cycles with no transaction and no register write
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_wr_en || (i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("boot_bank_fallback_controller regression: fail");
        $finish;
    end

endmodule
